[src/ddfp_pkg.sv]
// shared types and constants for the delimited decimal field parser
// no dependencies
`default_nettype none

package ddfp_pkg;

  localparam int unsigned FIELD_CHARS_DEF = 32;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [CH_W-1:0]    DELIM_RST     = 8'd44;
  localparam logic [COUNT_W-1:0] MAX_COUNT_RST = 12'd4095;

  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIMITER = 2'd0,
    REG_MAX_COUNT = 2'd1,
    REG_BYTE_MODE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

endpackage

`default_nettype wire

[src/delimited_decimal_field_parser_top.sv]
// delimited decimal field parser, top level
// depends on ddfp_pkg
`default_nettype none

// Parses a character stream (one character per item, tlast marks the end item)
// into delimiter-separated fields, each converted like atoi. A character is
// held in the input register until it can advance, then field state and the
// result register are updated, so one item is accepted per clock while the
// result stream is not stalled. A delimiter that closes an emitted field, and
// every end item, give one result; other items give none. Configuration
// writes are taken at any time (ready is tied high) but must only happen while
// the block is idle.
module delimited_decimal_field_parser_top #(
  parameter int unsigned FieldChars = ddfp_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // cfg write channel
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [ddfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ddfp_pkg::CFG_W-1:0]      cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [ddfp_pkg::CH_W-1:0]       s_axis_tdata,   // [7:0] ch
  input  wire logic                            s_axis_tlast,   // is_end
  // result stream
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [ddfp_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] value, [43:32] count
  output      logic                            m_axis_tuser,   // value_valid
  output      logic                            m_axis_tlast    // done_res
);

  import ddfp_pkg::*;

  localparam int unsigned LenW = $clog2(FieldChars + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(FieldChars);

  // config registers
  logic [CH_W-1:0]    delim_q;
  logic [COUNT_W-1:0] max_count_q;
  logic               byte_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= DELIM_RST;
      max_count_q <= MAX_COUNT_RST;
      byte_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DELIMITER: delim_q     <= cfg_data_i[CH_W-1:0];
        REG_MAX_COUNT: max_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_BYTE_MODE: byte_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic            in_valid_q;
  logic [CH_W-1:0] in_ch_q;
  logic            in_end_q;
  logic            advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q  <= s_axis_tdata;
      in_end_q <= s_axis_tlast;
    end
  end

  // field state
  logic [LenW-1:0]    len_q, len_d;
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0] emitted_q, emitted_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_vv_q, out_vv_d;
  logic               out_done_q, out_done_d;

  logic               is_digit, is_space, is_delim, can_emit;
  logic [VALUE_W-1:0] digit_val, acc_x10, emit_val;
  logic [COUNT_W-1:0] emitted_inc;

  always_comb begin
    is_digit  = (in_ch_q >= CH_ZERO) && (in_ch_q <= CH_NINE);
    is_space  = (in_ch_q == CH_SPACE) || ((in_ch_q >= CH_TAB) && (in_ch_q <= CH_CR));
    is_delim  = (in_ch_q == delim_q);
    digit_val = VALUE_W'(in_ch_q[3:0]);
    acc_x10   = (acc_q << 3) + (acc_q << 1);
    can_emit  = (emitted_q < max_count_q) && (len_q != '0) && (len_q < LenMax);
    emit_val  = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;
    if (byte_mode_q) begin
      emit_val = {{(VALUE_W-CH_W){1'b0}}, emit_val[CH_W-1:0]};
    end
    emitted_inc = emitted_q + COUNT_W'(1);

    len_d       = len_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    emitted_d   = emitted_q;
    out_valid_d = m_axis_tvalid && !m_axis_tready;
    out_value_d = out_value_q;
    out_count_d = out_count_q;
    out_vv_d    = out_vv_q;
    out_done_d  = out_done_q;

    if (advance) begin
      priority if (in_end_q) begin
        out_valid_d = 1'b1;
        out_vv_d    = can_emit;
        out_value_d = can_emit ? emit_val : '0;
        out_done_d  = 1'b1;
        out_count_d = can_emit ? emitted_inc : emitted_q;
        len_d       = '0;
        phase_d     = PH_SKIP;
        neg_d       = 1'b0;
        acc_d       = '0;
        emitted_d   = '0;
      end else if (is_delim) begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_vv_d    = 1'b1;
          out_value_d = emit_val;
          out_done_d  = 1'b0;
          out_count_d = emitted_inc;
          emitted_d   = emitted_inc;
        end
        len_d   = '0;
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        acc_d   = '0;
      end else if (len_q < LenMax) begin
        len_d = len_q + LenW'(1);
        unique case (phase_q)
          PH_SKIP: begin
            priority if (is_space) begin
              phase_d = PH_SKIP;
            end else if ((in_ch_q == CH_PLUS) || (in_ch_q == CH_MINUS)) begin
              neg_d   = (in_ch_q == CH_MINUS);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              acc_d   = digit_val;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              acc_d   = acc_x10 + digit_val;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_DONE: phase_d = PH_DONE;
          default: phase_d = PH_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_count_q <= out_count_d;
    out_vv_q    <= out_vv_d;
    out_done_q  <= out_done_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-VALUE_W-COUNT_W){1'b0}}, out_count_q, out_value_q};
  assign m_axis_tuser  = out_vv_q;
  assign m_axis_tlast  = out_done_q;

  // checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("field length past limit");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_end_q |=> (emitted_q == '0) && (len_q == '0) && (phase_q == PH_SKIP))
    else $error("end item did not clear state");

  a_digits_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_SKIP) |-> (len_q != '0))
    else $error("phase moved without a character");

  a_no_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q && !out_vv_q |-> (out_value_q == '0))
    else $error("end result without value carries nonzero value");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |=> $stable(emitted_q) && $stable(acc_q))
    else $error("state changed while result stalled");

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for delimited_decimal_field_parser_top
// drives character streams with random gaps and back-pressure, predicts every result
// depends on ddfp_pkg and the parser top level
`timescale 1ns / 100ps

module tb;
  import ddfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic            last;
  } stream_char_t;

  typedef struct {
    logic               has_value;
    logic [VALUE_W-1:0] value;
    logic               done;
    logic [COUNT_W-1:0] count;
  } field_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CH_W-1:0]        s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  delimited_decimal_field_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser mirror: registers and field state
  logic [CH_W-1:0]    delim   = DELIM_RST;
  logic [COUNT_W-1:0] max_cnt = MAX_COUNT_RST;
  logic               byte_md = 1'b0;
  logic [5:0]         field_len = '0;
  phase_e             phase = PH_SKIP;
  logic               neg = 1'b0;
  logic [VALUE_W-1:0] acc = '0;
  logic [COUNT_W-1:0] emitted = '0;

  stream_char_t  char_stream[$];
  field_result_t values_due[$];
  stream_char_t  next_char;
  int unsigned   chars_queued = 0;
  int unsigned   chars_taken = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   feed_gap = 0;
  int unsigned   hold_off = 0;
  bit            no_idle = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void clear_field();
    field_len = '0;
    phase = PH_SKIP;
    neg = 1'b0;
    acc = '0;
  endfunction

  function bit take_value(output logic [VALUE_W-1:0] v);
    v = '0;
    if (emitted >= max_cnt) return 1'b0;
    if (field_len == 0 || field_len >= FIELD_CHARS_DEF) return 1'b0;
    v = neg ? (32'd0 - acc) : acc;
    if (byte_md) v = v & 32'h0000_00ff;
    emitted = emitted + 1'b1;
    return 1'b1;
  endfunction

  function void parser_step(input logic [CH_W-1:0] c, input logic last);
    field_result_t      r;
    logic [VALUE_W-1:0] v;
    bit                 ok;
    bit                 digit;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (last) begin
      ok = take_value(v);
      r.has_value = ok;
      r.value = ok ? v : '0;
      r.done = 1'b1;
      r.count = emitted;
      values_due.push_back(r);
      clear_field();
      emitted = '0;
    end else if (c == delim) begin
      ok = take_value(v);
      clear_field();
      if (ok) begin
        r.has_value = 1'b1;
        r.value = v;
        r.done = 1'b0;
        r.count = emitted;
        values_due.push_back(r);
      end
    end else if (field_len < FIELD_CHARS_DEF) begin
      case (phase)
        PH_SKIP: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            phase = PH_SIGN;
          end else if (digit) begin
            acc = 32'(c - CH_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (digit) begin
            acc = acc * 32'd10 + 32'(c - CH_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      field_len = field_len + 1'b1;
    end
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parser_step(s_axis_tdata, s_axis_tlast);
        chars_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (char_stream.size() > 0) begin
          next_char = char_stream.pop_front();
          s_axis_tdata <= next_char.ch;
          s_axis_tlast <= next_char.last;
          s_axis_tvalid <= 1'b1;
          feed_gap = gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (values_due.size() == 0) begin
          note_mismatch("result with nothing due, value", m_axis_tdata[31:0], '0);
        end else begin
          want = values_due.pop_front();
          if (m_axis_tuser !== want.has_value)
            note_mismatch("value_valid", 32'(m_axis_tuser), 32'(want.has_value));
          if (m_axis_tdata[31:0] !== want.value)
            note_mismatch("value", m_axis_tdata[31:0], want.value);
          if (m_axis_tlast !== want.done)
            note_mismatch("done", 32'(m_axis_tlast), 32'(want.done));
          if (m_axis_tdata[43:32] !== want.count)
            note_mismatch("count", 32'(m_axis_tdata[43:32]), 32'(want.count));
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        hold_off = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_char(logic [CH_W-1:0] c);
    stream_char_t s;
    s.ch = c;
    s.last = 1'b0;
    char_stream.push_back(s);
    chars_queued++;
  endtask

  task automatic push_end();
    stream_char_t s;
    s.ch = 8'($urandom_range(0, 255));
    s.last = 1'b1;
    char_stream.push_back(s);
    chars_queued++;
  endtask

  task automatic push_text(string txt);
    for (int i = 0; i < txt.len(); i++) push_char(txt[i]);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DELIMITER: delim = d[CH_W-1:0];
      REG_MAX_COUNT: max_cnt = d[COUNT_W-1:0];
      REG_BYTE_MODE: byte_md = d[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_regs(logic [7:0] d, logic [11:0] m, logic b);
    write_reg(REG_DELIMITER, {4'd0, d});
    write_reg(REG_MAX_COUNT, m);
    write_reg(REG_BYTE_MODE, {11'd0, b});
  endtask

  task automatic wait_idle();
    while (chars_taken != chars_queued || values_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one record of fields, or a burst of noise
  task automatic add_record();
    int unsigned nfields;
    int unsigned kind;
    int unsigned nd;
    int unsigned sg;
    string       big[4];
    big[0] = "2147483647";
    big[1] = "2147483648";
    big[2] = "4294967295";
    big[3] = "4294967296";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 7) == 0) push_char(delim);
        else push_char(8'($urandom_range(0, 255)));
      end
    end else begin
      nfields = $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) push_char(delim);
        kind = $urandom_range(0, 99);
        if (kind < 8) continue;
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 5) == 0) push_char(CH_SPACE);
          else push_char(8'(CH_TAB + $urandom_range(0, 4)));
        end
        sg = $urandom_range(0, 2);
        if (sg == 1) push_char(CH_PLUS);
        else if (sg == 2) push_char(CH_MINUS);
        if (kind < 14) begin
          push_text(big[$urandom_range(0, 3)]);
        end else begin
          if (kind < 80) nd = $urandom_range(1, 10);
          else if (kind < 94) nd = $urandom_range(11, 31);
          else nd = $urandom_range(28, 40);
          repeat (nd) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) push_end();
  endtask

  initial begin
    int unsigned start;
    int unsigned r;
    logic [7:0]  d;
    logic [11:0] m;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: whitespace, signs, empty fields, code zero in a field
    set_regs(DELIM_RST, MAX_COUNT_RST, 1'b0);
    push_text(" -5,+,,7");
    push_char(8'h00);
    push_text("3,");
    push_char(8'hff);
    push_end();
    wait_idle();

    // delimiter code zero, byte mode, count limit reached
    set_regs(8'd0, 12'd2, 1'b1);
    push_text("-1");
    push_char(8'h00);
    push_char("9");
    push_char(8'h00);
    push_char("4");
    push_end();
    wait_idle();

    // nothing may be emitted
    set_regs(8'd255, 12'd0, 1'b0);
    push_char("3");
    push_char(8'd255);
    push_end();
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      r = $urandom_range(0, 99);
      if (p == 0) d = 8'd1;
      else if (r < 40) d = DELIM_RST;
      else if (r < 55) d = CH_SPACE;
      else if (r < 65) d = CH_MINUS;
      else if (r < 75) d = 8'(CH_ZERO + 5);
      else d = 8'($urandom_range(1, 255));
      r = $urandom_range(0, 99);
      if (r < 50) m = MAX_COUNT_RST;
      else if (r < 75) m = 12'($urandom_range(0, 4095));
      else m = 12'($urandom_range(0, 5));
      set_regs(d, m, 1'($urandom_range(0, 1)));
      no_idle = (p == 5);
      start = chars_queued;
      while (chars_queued - start < 112) add_record();
      push_end();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && values_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
